// File: rtl/hts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_pkg
// Types and constants shared by the hybrid task scheduler modules.
// ----------------------------------------------------------------------------
package hts_pkg;

  localparam int MAX_RESULTS = 8;
  localparam int CNT_W       = 4;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_DISPATCH = 2'd3;

  localparam logic [2:0] KIND_ADD     = 3'd0;
  localparam logic [2:0] KIND_DELETE  = 3'd1;
  localparam logic [2:0] KIND_RUN_PRE = 3'd2;
  localparam logic [2:0] KIND_RUN_COOP = 3'd3;
  localparam logic [2:0] KIND_NONE    = 3'd4;

  localparam logic [7:0] PEND_MAX = 8'hFF;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  task_id;
    logic [15:0] start_delay;
    logic [15:0] repeat_period;
    logic        cooperative;
    logic [2:0]  target_slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    logic [7:0] run_task;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  task_id;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  pending;
    logic        coop;
  } slot_word_t;

  typedef struct packed {
    logic accept;
    logic prime;
    logic step;
    logic flush;
  } hts_cmd_t;

  typedef struct packed {
    logic out_free;
    logic walk_block;
    logic idx_last;
    logic item_walks;
  } hts_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRIME,
    ST_WALK,
    ST_FLUSH
  } hts_state_t;

endpackage

// File: rtl/hts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_ctrl
// Sequencer for the scheduler: accepts transactions and walks the slot table.
// ----------------------------------------------------------------------------
module hts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  hts_pkg::hts_status_t status,
  output hts_pkg::hts_cmd_t    cmd
);
  import hts_pkg::*;

  hts_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !status.out_free;
        if (in_valid && status.out_free) begin
          cmd.accept = 1'b1;
          if (status.item_walks) begin
            state_nxt = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (!status.walk_block) begin
          cmd.step = 1'b1;
          if (status.idx_last) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (status.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/hts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hts_datapath
// Slot memory, occupancy bits, slot update logic, held result and output
// register of the scheduler.
// ----------------------------------------------------------------------------
module hts_datapath #(
  parameter int NUM_SLOTS = 8,
  parameter int IW        = 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hts_pkg::in_item_t    in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output hts_pkg::out_item_t   out_data,
  input  hts_pkg::hts_cmd_t    cmd,
  output hts_pkg::hts_status_t status
);
  import hts_pkg::*;

  slot_word_t            mem_r [NUM_SLOTS];
  slot_word_t            rd_r;
  logic [NUM_SLOTS-1:0]  used_r;
  logic [IW-1:0]         idx_r;
  logic [1:0]            op_r;
  logic                  held_valid_r;
  out_item_t             held_r;
  logic [CNT_W-1:0]      n_r;
  logic                  out_valid_r;
  out_item_t             out_r;

  logic [6:0]    found;
  logic          add_hit;
  logic          del_hit;
  logic [IW-1:0] next_idx;
  logic          cur_used;
  slot_word_t    upd;
  logic          clr;
  logic          rep;
  logic          report;
  logic [2:0]    rep_kind;
  out_item_t     new_res;
  logic          out_free;
  logic          out_load;
  out_item_t     out_nxt;
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  slot_word_t    mem_wdata;
  logic          is_add;
  logic          is_del;

  assign out_free = !out_valid_r || !out_stall;
  assign is_add   = cmd.accept && (in_data.opcode == OP_ADD);
  assign is_del   = cmd.accept && (in_data.opcode == OP_DELETE);
  assign del_hit  = 7'(in_data.target_slot) < 7'(NUM_SLOTS);

  // lowest free slot
  always_comb begin
    found   = 7'(NUM_SLOTS);
    add_hit = 1'b0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        found   = 7'(i);
        add_hit = 1'b1;
      end
    end
  end

  assign next_idx = (idx_r == IW'(NUM_SLOTS - 1)) ? '0 : idx_r + 1'b1;
  assign cur_used = used_r[idx_r];

  always_comb begin
    upd      = rd_r;
    clr      = 1'b0;
    rep      = 1'b0;
    rep_kind = KIND_RUN_PRE;
    if (op_r == OP_TICK) begin
      if (cur_used) begin
        if (rd_r.delay == '0) begin
          if (rd_r.coop) begin
            if (rd_r.pending != PEND_MAX) begin
              upd.pending = rd_r.pending + 1'b1;
            end
          end else begin
            rep = 1'b1;
          end
          if (rd_r.period != '0) begin
            upd.delay = rd_r.period;
          end else if (!rd_r.coop) begin
            clr = 1'b1;
          end
        end else begin
          upd.delay = rd_r.delay - 1'b1;
        end
      end
    end else begin
      rep_kind = KIND_RUN_COOP;
      if (cur_used && rd_r.coop && (rd_r.pending != '0)) begin
        upd.pending = rd_r.pending - 1'b1;
        rep         = 1'b1;
        if (rd_r.period == '0) begin
          clr = 1'b1;
        end
      end
    end
  end

  assign report = rep && (n_r < CNT_W'(MAX_RESULTS));

  always_comb begin
    new_res.kind     = rep_kind;
    new_res.slot     = 4'(idx_r);
    new_res.run_task = rd_r.task_id;
    new_res.last     = 1'b0;
  end

  assign status.out_free   = out_free;
  assign status.walk_block = report && held_valid_r && !out_free;
  assign status.idx_last   = (idx_r == IW'(NUM_SLOTS - 1));
  assign status.item_walks = (in_data.opcode == OP_TICK) || (in_data.opcode == OP_DISPATCH);

  // slot memory
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = upd;
    if (is_add && add_hit) begin
      mem_we            = 1'b1;
      mem_waddr         = found[IW-1:0];
      mem_wdata.task_id = in_data.task_id;
      mem_wdata.delay   = in_data.start_delay;
      mem_wdata.period  = in_data.repeat_period;
      mem_wdata.pending = '0;
      mem_wdata.coop    = in_data.cooperative;
    end else if (cmd.step) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_waddr] <= mem_wdata;
    end
    if (cmd.prime) begin
      rd_r <= mem_r[0];
    end else if (cmd.step) begin
      rd_r <= mem_r[next_idx];
    end
  end

  // output selection
  always_comb begin
    out_load = 1'b0;
    out_nxt  = out_r;
    if (is_add) begin
      out_load         = 1'b1;
      out_nxt.kind     = KIND_ADD;
      out_nxt.slot     = found[3:0];
      out_nxt.run_task = '0;
      out_nxt.last     = 1'b1;
    end else if (is_del) begin
      out_load         = 1'b1;
      out_nxt.kind     = del_hit ? KIND_DELETE : KIND_NONE;
      out_nxt.slot     = {1'b0, in_data.target_slot};
      out_nxt.run_task = '0;
      out_nxt.last     = 1'b1;
    end else if (cmd.step && report && held_valid_r) begin
      out_load = 1'b1;
      out_nxt  = held_r;
    end else if (cmd.flush) begin
      out_load = 1'b1;
      if (held_valid_r) begin
        out_nxt      = held_r;
        out_nxt.last = 1'b1;
      end else begin
        out_nxt.kind     = KIND_NONE;
        out_nxt.slot     = '0;
        out_nxt.run_task = '0;
        out_nxt.last     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= out_nxt;
    end
    if (cmd.accept) begin
      op_r <= in_data.opcode;
    end
    if (cmd.step && report) begin
      held_r <= new_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      out_valid_r  <= 1'b0;
      held_valid_r <= 1'b0;
      n_r          <= '0;
      idx_r        <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (is_add && add_hit) begin
        used_r[found[IW-1:0]] <= 1'b1;
      end
      if (is_del) begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (7'(in_data.target_slot) == 7'(i)) begin
            used_r[i] <= 1'b0;
          end
        end
      end
      if (cmd.prime) begin
        idx_r        <= '0;
        held_valid_r <= 1'b0;
        n_r          <= '0;
      end else if (cmd.step) begin
        idx_r <= next_idx;
        if (clr) begin
          used_r[idx_r] <= 1'b0;
        end
        if (report) begin
          held_valid_r <= 1'b1;
          n_r          <= n_r + 1'b1;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/hybrid_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hybrid_task_scheduler
// Time-triggered task table with preemptive runs on tick and cooperative runs
// on dispatch.
//
//   channel | ports                         | direction
//   in      | in_valid, in_stall, in_data   | item in: opcode and task fields
//   out     | out_valid, out_stall, out_data| results: kind, slot, task, last
//
// add and delete give one result.
// tick and dispatch walk the slot table: the slot memory is read and
// written back one slot per cycle, except while out_stall holds the walk.
// out_stall holds the walk only when a new result meets a held result and a full output.
// reset empties the table through the occupancy bits.
// ----------------------------------------------------------------------------
module hybrid_task_scheduler #(
  parameter int NUM_SLOTS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hts_pkg::out_item_t out_data
);
  import hts_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  hts_cmd_t    cmd;
  hts_status_t status;

  hts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  hts_datapath #(
    .NUM_SLOTS (NUM_SLOTS),
    .IW        (IW)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule
